@@ rtl/utc_pkg.sv @@
`default_nettype none
package utc_pkg;
    localparam int HeaderBytesDefault = 32;
    localparam int SparePortsDefault  = 2;

    localparam logic [15:0] PORT_IKE    = 16'd500;
    localparam logic [15:0] PORT_NATT   = 16'd4500;
    localparam logic [15:0] PORT_L2TP   = 16'd1701;
    localparam logic [15:0] PORT_VXLAN  = 16'd4789;
    localparam logic [15:0] PORT_GENEVE = 16'd6081;
    localparam logic [15:0] PORT_WG     = 16'd51820;
    localparam logic [15:0] PORT_VPN    = 16'd1194;

    localparam logic [1:0] REG_EXTRA_A     = 2'd0;
    localparam logic [1:0] REG_EXTRA_B     = 2'd1;
    localparam logic [1:0] REG_EXTRA_COUNT = 2'd2;

    localparam logic [3:0] KIND_NONE   = 4'd0;
    localparam logic [3:0] KIND_IKE    = 4'd1;
    localparam logic [3:0] KIND_ESP    = 4'd2;
    localparam logic [3:0] KIND_L2TP   = 4'd3;
    localparam logic [3:0] KIND_VXLAN  = 4'd4;
    localparam logic [3:0] KIND_GENEVE = 4'd5;
    localparam logic [3:0] KIND_WG     = 4'd6;
    localparam logic [3:0] KIND_VPN    = 4'd7;
    localparam logic [3:0] KIND_DTLS   = 4'd8;

    typedef struct packed {
        logic       trunc;
        logic       spi;
        logic       natt;
        logic [2:0] flags;
        logic [15:0] inner;
        logic [31:0] ident;
        logic [7:0] msg;
        logic [1:0] variant;
        logic [3:0] kind;
    } cls_t;

    typedef struct packed {
        logic ike;
        logic natt;
        logic l2tp;
        logic vxlan;
        logic geneve;
        logic wg;
        logic vpn;
    } port_hits_t;
endpackage
`default_nettype wire

@@ rtl/utc_classify.sv @@
`default_nettype none
module utc_classify
    import utc_pkg::*;
#(
    parameter int HEADER_BYTES = HeaderBytesDefault
)
(
    input  wire logic [HEADER_BYTES*8-1:0] hdr,
    input  wire logic [15:0]               size,
    input  wire port_hits_t                hits,
    output cls_t                           cls
);
    function automatic logic [7:0] hb(input logic [HEADER_BYTES*8-1:0] h, input int i);
        return h[i*8 +: 8];
    endfunction

    logic [31:0] sz;
    logic [31:0] ike_len, natt_len;
    logic [3:0]  ike_major, natt_major;
    logic        ike_ok, natt_ike_ok, zero_marker;
    logic        l2tp_ok, l2tp_v2, vxlan_ok, geneve_ok, wg_ok, vpn_ok, dtls_ok;
    logic [4:0]  op;
    logic [15:0] dver;
    logic [1:0]  dvar;
    logic [31:0] dlen;
    logic [7:0]  b0, b1;

    always_comb
    begin
        sz = {16'd0, size};
        b0 = hb(hdr, 0);
        b1 = hb(hdr, 1);
        ike_major = hdr[17*8+4 +: 4];
        ike_len = {hb(hdr, 24), hb(hdr, 25), hb(hdr, 26), hb(hdr, 27)};
        ike_ok = sz >= 32'd28 && (ike_major == 4'd1 || ike_major == 4'd2) && ike_len >= 32'd28;
        zero_marker = sz >= 32'd4 && {b0, b1, hb(hdr, 2), hb(hdr, 3)} == 32'd0;
        natt_major = hdr[21*8+4 +: 4];
        natt_len = {hb(hdr, 28), hb(hdr, 29), hb(hdr, 30), hb(hdr, 31)};
        natt_ike_ok = sz >= 32'd32 && (natt_major == 4'd1 || natt_major == 4'd2)
            && natt_len >= 32'd28;
        l2tp_ok = sz >= 32'd2;
        l2tp_v2 = b1[3:0] == 4'd2 && (b0 & 8'h34) == 8'd0 && (b1 & 8'hF0) == 8'd0;
        vxlan_ok = sz >= 32'd8 && b0 == 8'h08 && hb(hdr, 7) == 8'd0;
        geneve_ok = sz >= 32'd8 && b0[7:6] == 2'd0 && (b1 & 8'h3F) == 8'd0
            && (32'd8 + {24'd0, 2'd0, b0[5:0]} * 32'd4) <= sz;
        wg_ok = sz >= 32'd4 && hb(hdr, 1) == 8'd0 && hb(hdr, 2) == 8'd0 && hb(hdr, 3) == 8'd0
            && ((b0 == 8'd1 && sz == 32'd148) || (b0 == 8'd2 && sz == 32'd92)
            || (b0 == 8'd3 && sz == 32'd64) || (b0 == 8'd4 && sz >= 32'd16));
        op = b0[7:3];
        vpn_ok = sz >= 32'd1 && op != 5'd0 && op != 5'd2 && op != 5'd8 && op <= 5'd11;
        dver = {b1, hb(hdr, 2)};
        dvar = (dver == 16'hFEFF) ? 2'd0 : (dver == 16'hFEFD) ? 2'd1 : 2'd2;
        dtls_ok = sz >= 32'd13 && b0 >= 8'd20 && b0 <= 8'd23
            && (dver == 16'hFEFF || dver == 16'hFEFD || dver == 16'hFEFC);
        dlen = {16'd0, hb(hdr, 11), hb(hdr, 12)};

        cls = '0;
        priority if (hits.ike && ike_ok)
        begin
            cls.kind = KIND_IKE;
            cls.variant = ike_major[1:0];
            cls.msg = hb(hdr, 18);
            cls.trunc = ike_len > sz;
        end
        else if (hits.natt && !zero_marker)
        begin
            cls.kind = KIND_ESP;
            cls.natt = 1'b1;
            if (sz >= 32'd4)
            begin
                cls.ident = {b0, b1, hb(hdr, 2), hb(hdr, 3)};
                cls.spi = 1'b1;
            end
        end
        else if (hits.natt && natt_ike_ok)
        begin
            cls.kind = KIND_IKE;
            cls.variant = natt_major[1:0];
            cls.msg = hb(hdr, 22);
            cls.natt = 1'b1;
            cls.trunc = natt_len > (sz - 32'd4);
        end
        else if (hits.l2tp && l2tp_ok)
        begin
            cls.kind = KIND_L2TP;
            if (l2tp_v2)
            begin
                cls.variant = 2'd2;
                cls.msg = {7'd0, b0[7]};
                cls.flags = {b0[1], b0[3], b0[6]};
            end
            else
            begin
                cls.variant = 2'd3;
                cls.ident = {b0, b1, 16'd0};
                if (sz >= 32'd4)
                    cls.ident[15:0] = {hb(hdr, 2), hb(hdr, 3)};
                cls.spi = 1'b1;
            end
        end
        else if (hits.vxlan && vxlan_ok)
        begin
            cls.kind = KIND_VXLAN;
            cls.ident = {8'd0, hb(hdr, 4), hb(hdr, 5), hb(hdr, 6)};
            cls.spi = 1'b1;
        end
        else if (hits.geneve && geneve_ok)
        begin
            cls.kind = KIND_GENEVE;
            cls.inner = {hb(hdr, 2), hb(hdr, 3)};
            cls.ident = {8'd0, hb(hdr, 4), hb(hdr, 5), hb(hdr, 6)};
            cls.spi = 1'b1;
        end
        else if (hits.wg && wg_ok)
        begin
            cls.kind = KIND_WG;
            cls.msg = b0;
        end
        else if (hits.vpn && vpn_ok)
        begin
            cls.kind = KIND_VPN;
            cls.msg = {3'd0, op};
        end
        else if (dtls_ok)
        begin
            cls.kind = KIND_DTLS;
            cls.variant = dvar;
            cls.msg = b0;
            cls.trunc = (32'd13 + dlen) > sz;
        end
        else
        begin
            cls = '0;
        end
    end
endmodule
`default_nettype wire

@@ rtl/udp_tunnel_classifier.sv @@
// UDP tunnel classifier: takes a UDP payload one byte per transfer, with the UDP ports
// sampled on the first transfer of each packet, and on the transfer marked tlast emits
// one classification (IKE, NAT-T ESP/IKE, L2TP, VXLAN, Geneve, WireGuard, opcode VPN,
// DTLS, or none). One transfer is taken every clock unless a result waits on a stalled
// output; checks run between the input-stage header and the output register. Only the
// first HEADER_BYTES bytes are inspected; the byte count saturates at 65535. Configure
// the extra ports only while no packet is in flight.
`default_nettype none
module udp_tunnel_classifier
    import utc_pkg::*;
#(
    parameter int HEADER_BYTES = HeaderBytesDefault,
    parameter int SPARE_PORTS  = SparePortsDefault
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,   // data_byte, source_port, dest_port
    input  wire logic        s_tlast,
    input  wire logic        s_tuser,   // byte_valid
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [71:0]      m_tdata,   // tunnel_kind, variant, message_type, identifier,
                                        // inner_type, header_flags, over_natt, has_spi,
                                        // truncated, zero fill
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);
    localparam int IdxW = $clog2(HEADER_BYTES);

    logic [15:0] extra_a_reg, extra_b_reg;
    logic [1:0]  extra_count_reg;
    logic [HEADER_BYTES*8-1:0] hdr_reg;
    logic [15:0] count_reg, count_next;
    logic [15:0] src_reg, dst_reg, src_next, dst_next;
    logic        in_pkt_reg;
    logic        fire_reg;
    logic        out_valid_reg;
    cls_t        out_reg;
    cls_t        cls;
    port_hits_t  hits;
    logic        accept;
    logic [1:0]  eff_count;
    logic        ea_hit, eb_hit;

    assign cfg_ready = 1'b1;
    // pipeline keeps moving unless the result register is blocked while a new result waits
    assign s_tready = !(out_valid_reg && !m_tready && fire_reg);
    assign accept = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            extra_a_reg <= '0;
            extra_b_reg <= '0;
            extra_count_reg <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_EXTRA_A:     extra_a_reg <= cfg_data;
                REG_EXTRA_B:     extra_b_reg <= cfg_data;
                REG_EXTRA_COUNT: extra_count_reg <= cfg_data[1:0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        src_next = in_pkt_reg ? src_reg : s_tdata[23:8];
        dst_next = in_pkt_reg ? dst_reg : s_tdata[39:24];
        count_next = in_pkt_reg ? count_reg : 16'd0;
        if (s_tuser && count_next != 16'hFFFF)
            count_next = count_next + 16'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_pkt_reg <= 1'b0;
            count_reg <= '0;
            src_reg <= '0;
            dst_reg <= '0;
            fire_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            fire_reg <= accept && s_tlast;
            if (accept)
            begin
                in_pkt_reg <= !s_tlast;
                count_reg <= count_next;
                src_reg <= src_next;
                dst_reg <= dst_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && s_tuser && (!in_pkt_reg || count_reg < 16'(HEADER_BYTES)))
            hdr_reg[(in_pkt_reg ? count_reg[IdxW-1:0] : {IdxW{1'b0}})*8 +: 8] <= s_tdata[7:0];
    end

    always_comb
    begin
        eff_count = extra_count_reg;
        if (SPARE_PORTS < 2 && eff_count > 2'(SPARE_PORTS))
            eff_count = 2'(SPARE_PORTS);
        if (eff_count == 2'd3)
            eff_count = 2'd2;
        ea_hit = eff_count >= 2'd1 && (src_reg == extra_a_reg || dst_reg == extra_a_reg);
        eb_hit = eff_count >= 2'd2 && (src_reg == extra_b_reg || dst_reg == extra_b_reg);
        hits.ike    = ea_hit || eb_hit || src_reg == PORT_IKE    || dst_reg == PORT_IKE;
        hits.natt   = ea_hit || eb_hit || src_reg == PORT_NATT   || dst_reg == PORT_NATT;
        hits.l2tp   = ea_hit || eb_hit || src_reg == PORT_L2TP   || dst_reg == PORT_L2TP;
        hits.vxlan  = ea_hit || eb_hit || src_reg == PORT_VXLAN  || dst_reg == PORT_VXLAN;
        hits.geneve = ea_hit || eb_hit || src_reg == PORT_GENEVE || dst_reg == PORT_GENEVE;
        hits.wg     = ea_hit || eb_hit || src_reg == PORT_WG     || dst_reg == PORT_WG;
        hits.vpn    = ea_hit || eb_hit || src_reg == PORT_VPN    || dst_reg == PORT_VPN;
    end

    utc_classify #(.HEADER_BYTES(HEADER_BYTES)) u_classify
    (
        .hdr  (hdr_reg),
        .size (count_reg),
        .hits (hits),
        .cls  (cls)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (fire_reg && s_tready)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (fire_reg && s_tready)
            out_reg <= cls;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata = {4'd0, out_reg.trunc, out_reg.spi, out_reg.natt, out_reg.flags,
                      out_reg.inner, out_reg.ident, out_reg.msg, out_reg.variant,
                      out_reg.kind};
endmodule
`default_nettype wire

@@ rtl/utc_checker.sv @@
`default_nettype none
module utc_checker
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        s_tlast,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [71:0] m_tdata
);
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result dropped while stalled");
    a_kind: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[3:0] <= 4'd8)
        else $error("kind out of range");
    a_result_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready && s_tlast, 2))
        else $error("result without last byte");
    a_idle_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output");
endmodule

bind udp_tunnel_classifier utc_checker u_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
`default_nettype wire
